// ===== rtl/core/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
// Used by every module under rtl/core; depends on nothing.
package lpd_pkg;

  localparam int HEADER_BYTES_DEF = 8;
  localparam int LEN_W            = 64;   // widest length a header can carry
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
  } lpd_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] err_code;
  } lpd_res_t;

endpackage

// ===== rtl/core/length_prefixed_deframer.sv =====
// Length-prefixed deframer: splits a byte stream into frames.
// Input beat: s_tuser = kind (0 byte, 1 tick, 2 restart), s_tdata = stream byte.
// Output beat: m_tuser = out_kind (0 body byte, 1 empty frame, 2 error),
//   m_tdata = {err_code, out_byte}, m_tlast on final body byte / empty frame.
// Each frame is a HEADER_BYTES big-endian length then that many body bytes.
// Zero lengths are delivered or rejected per allow_empty; lengths above
// frame_limit are rejected; a tick count reaching a nonzero timeout_ticks (counted
// from header start) raises a timeout error. Any error halts the block until a
// restart beat; halted bytes and ticks are dropped.
// Config: cfg_we writes cfg_data into register cfg_index (0 frame_limit,
//   1 allow_empty, 2 timeout_ticks); write only while idle.
// Timing: one beat per cycle sustained while the sink keeps m_tready high. An input
//   register and a result register bracket a single pass of state update; a result
//   is loaded into the result register when the core takes its beat from the input register.
// Stall: the result register holds while m_tready is low; the input register
//   takes one more beat only if it is empty, then s_tready drops until the sink drains.
// Reset (rst, synchronous): header gather restarts, config goes to defaults
//   (max 65536, empty rejected, no timeout), both registers empty.
module length_prefixed_deframer #(
  parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  input  logic [1:0]                     s_tuser,   // [1:0] kind
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [7:0] out_byte, [9:8] err_code
  output logic [1:0]                     m_tuser,   // [1:0] out_kind
  output logic                           m_tlast,
  // config writes
  input  logic                           cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpd_pkg::*;

  lpd_item_t s_item;
  lpd_item_t item;
  logic      item_valid;
  logic      take;
  logic      out_ready;
  logic      res_load;
  lpd_res_t  res;
  lpd_res_t  m_res;

  assign s_item.kind    = s_tuser;
  assign s_item.in_byte = s_tdata;

  lpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lpd_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  lpd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .res        (res),
    .load_ready (out_ready),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_res      (m_res)
  );

  // result beat packing
  assign m_tdata = {6'd0, m_res.err_code, m_res.out_byte};
  assign m_tuser = m_res.out_kind;
  assign m_tlast = m_res.last;

endmodule

// ===== rtl/core/lpd_in_stage.sv =====
// Input register for the deframer: holds one accepted beat until the core takes it.
// Depends on lpd_pkg.
module lpd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  lpd_pkg::lpd_item_t   s_item,
  input  logic                 take,
  output logic                 item_valid,
  output lpd_pkg::lpd_item_t   item
);
  import lpd_pkg::*;

  assign s_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

// ===== rtl/core/lpd_out_stage.sv =====
// Result register for the deframer: one result beat held until the sink takes it.
// Depends on lpd_pkg.
module lpd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lpd_pkg::lpd_res_t   res,
  output logic                load_ready,
  output logic                m_valid,
  input  logic                m_ready,
  output lpd_pkg::lpd_res_t   m_res
);
  import lpd_pkg::*;

  assign load_ready = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

// ===== rtl/core/lpd_core.sv =====
// Deframer state machine and config registers: header gather, length checks,
// body countdown, tick timeout. Depends on lpd_pkg.
module lpd_core #(
  parameter int HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               item_valid,
  input  lpd_pkg::lpd_item_t                 item,
  input  logic                               out_ready,
  output logic                               take,
  output logic                               res_load,
  output lpd_pkg::lpd_res_t                  res
);
  import lpd_pkg::*;

  localparam int         ACC_W    = 8 * HEADER_BYTES;
  localparam logic [2:0] HDR_CODE = 3'(HEADER_BYTES % 8);  // count wraps at 8

  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [1:0] IN_BYTE    = 2'd0;
  localparam logic [1:0] IN_TICK    = 2'd1;
  localparam logic [1:0] IN_RESTART = 2'd2;

  localparam logic [1:0] OUT_BYTE  = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;

  localparam logic [1:0] ERR_EMPTY   = 2'd0;
  localparam logic [1:0] ERR_LARGE   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  // config registers
  logic [31:0] frame_limit;
  logic        allow_empty;
  logic [31:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit   <= 32'd65536;
      allow_empty   <= 1'b0;
      timeout_ticks <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX:     frame_limit   <= cfg_data;
        CFG_EMPTY:   allow_empty   <= cfg_data[0];
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        default:     ;
      endcase
    end
  end

  phase_t           phase, phase_next;
  logic [2:0]       hdr_cnt, hdr_cnt_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [31:0]      rem, rem_next;      // body never exceeds frame_limit
  logic [31:0]      elapsed, elapsed_next;
  logic             res_has;

  logic [ACC_W-1:0] acc_shift;
  logic [LEN_W-1:0] acc_ext;
  logic [2:0]       cnt_inc;
  logic [31:0]      el_inc;
  logic [31:0]      rem_dec;

  assign take     = item_valid && out_ready;
  assign res_load = take && res_has;

  always_comb begin
    acc_shift = (acc << 8) | ACC_W'(item.in_byte);
    acc_ext   = LEN_W'(acc_shift);
    cnt_inc   = hdr_cnt + 3'd1;
    el_inc    = (elapsed == '1) ? elapsed : elapsed + 32'd1;
    rem_dec   = rem - 32'd1;

    phase_next   = phase;
    hdr_cnt_next = hdr_cnt;
    acc_next     = acc;
    rem_next     = rem;
    elapsed_next = elapsed;
    res_has      = 1'b0;
    res          = '0;

    if (item.kind == IN_RESTART) begin
      phase_next   = PH_HEADER;
      hdr_cnt_next = '0;
      acc_next     = '0;
      rem_next     = '0;
      elapsed_next = '0;
    end else if (item.kind == IN_TICK && phase != PH_HALT) begin
      elapsed_next = el_inc;
      if (timeout_ticks != '0 && el_inc >= timeout_ticks) begin
        phase_next   = PH_HALT;
        res_has      = 1'b1;
        res.out_kind = OUT_ERROR;
        res.err_code = ERR_TIMEOUT;
      end
    end else if (item.kind == IN_BYTE && phase == PH_HEADER) begin
      acc_next     = acc_shift;
      hdr_cnt_next = cnt_inc;
      if (cnt_inc == HDR_CODE) begin
        if (acc_ext == '0) begin
          res_has = 1'b1;
          if (!allow_empty) begin
            phase_next   = PH_HALT;
            res.out_kind = OUT_ERROR;
            res.err_code = ERR_EMPTY;
          end else begin
            hdr_cnt_next = '0;
            acc_next     = '0;
            rem_next     = '0;
            elapsed_next = '0;
            res.out_kind = OUT_EMPTY;
            res.last     = 1'b1;
          end
        end else if (acc_ext > LEN_W'(frame_limit)) begin
          phase_next   = PH_HALT;
          res_has      = 1'b1;
          res.out_kind = OUT_ERROR;
          res.err_code = ERR_LARGE;
        end else begin
          phase_next   = PH_BODY;
          hdr_cnt_next = '0;
          rem_next     = 32'(acc_ext);
        end
      end
    end else if (item.kind == IN_BYTE && phase == PH_BODY) begin
      res_has      = 1'b1;
      res.out_kind = OUT_BYTE;
      res.out_byte = item.in_byte;
      rem_next     = rem_dec;
      if (rem_dec == '0) begin
        res.last     = 1'b1;
        phase_next   = PH_HEADER;
        hdr_cnt_next = '0;
        acc_next     = '0;
        elapsed_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEADER;
      hdr_cnt <= '0;
      acc     <= '0;
      rem     <= '0;
      elapsed <= '0;
    end else if (take) begin
      phase   <= phase_next;
      hdr_cnt <= hdr_cnt_next;
      acc     <= acc_next;
      rem     <= rem_next;
      elapsed <= elapsed_next;
    end
  end

`ifndef SYNTHESIS
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> rem != '0)
    else $error("body phase with nothing left to read");

  a_header_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> rem == '0)
    else $error("stale body count while gathering header");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    res_load && res.out_kind == OUT_ERROR |=> phase == PH_HALT)
    else $error("error beat without halt");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT && item.kind != IN_RESTART |-> !res_load)
    else $error("result while halted");
`endif

endmodule

// ===== tb/lpd_tb_pkg.sv =====
// Verification-side codes and the frame scoreboard for the deframer testbench.
// Predicts output beats from accepted input beats; depends on lpd_pkg only.
package lpd_tb_pkg;

  import lpd_pkg::*;

  // input beat kinds (s_tuser)
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // output beat kinds (m_tuser)
  localparam logic [1:0] OUT_BODY  = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_EMPTY     = 2'd0;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MAX_BYTES   = 2'd0;
  localparam logic [1:0] REG_ALLOW_EMPTY = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [1:0] REG_SPARE       = 2'd3;

  typedef enum logic [1:0] {RX_HEADER, RX_BODY, RX_HALTED} rx_phase_t;

  class frame_scoreboard;
    // register copies, reset values
    logic [31:0] max_bytes     = 32'd65536;
    logic        allow_empty   = 1'b0;
    logic [31:0] timeout_ticks = 32'd0;

    // deframer state
    rx_phase_t   phase    = RX_HEADER;
    logic [2:0]  hdr_cnt  = '0;
    logic [63:0] len_acc  = '0;
    logic [63:0] body_left = '0;
    logic [31:0] ticks    = '0;

    lpd_res_t expected_beats[$];
    int       errors    = 0;
    int       n_results = 0;

    function void restart_header();
      phase     = RX_HEADER;
      hdr_cnt   = '0;
      len_acc   = '0;
      body_left = '0;
      ticks     = '0;
    endfunction

    function void push_beat(logic [1:0] kind, logic [7:0] data, logic last,
                            logic [1:0] code);
      lpd_res_t r;
      r.out_kind = kind;
      r.out_byte = data;
      r.last     = last;
      r.err_code = code;
      expected_beats.insert(expected_beats.size(), r);
    endfunction

    function void halt(logic [1:0] code);
      phase = RX_HALTED;
      push_beat(OUT_ERROR, 8'h00, 1'b0, code);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MAX_BYTES:   max_bytes     = val;
        REG_ALLOW_EMPTY: allow_empty   = val[0];
        REG_TIMEOUT:     timeout_ticks = val;
        default: ;  // spare index is a no-op
      endcase
    endfunction

    // one accepted input beat
    function void take_input(logic [1:0] kind, logic [7:0] data);
      if (kind == KIND_RESTART) begin
        restart_header();
      end else if (kind == KIND_UNUSED || phase == RX_HALTED) begin
        // dropped
      end else if (kind == KIND_TICK) begin
        if (ticks != '1) ticks++;
        if (timeout_ticks != 0 && ticks >= timeout_ticks) halt(ERR_TIMEOUT);
      end else if (phase == RX_HEADER) begin
        len_acc = {len_acc[55:0], data};
        hdr_cnt++;
        if (hdr_cnt == 3'(HEADER_BYTES_DEF)) begin
          if (len_acc == 0) begin
            if (!allow_empty) begin
              halt(ERR_EMPTY);
            end else begin
              restart_header();
              push_beat(OUT_EMPTY, 8'h00, 1'b1, ERR_EMPTY);
            end
          end else if (len_acc > {32'h0, max_bytes}) begin
            halt(ERR_TOO_LARGE);
          end else begin
            body_left = len_acc;
            hdr_cnt   = '0;
            phase     = RX_BODY;
          end
        end
      end else begin
        body_left--;
        if (body_left == 0) begin
          restart_header();
          push_beat(OUT_BODY, data, 1'b1, ERR_EMPTY);
        end else begin
          push_beat(OUT_BODY, data, 1'b0, ERR_EMPTY);
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch on output beat %0d: %s", n_results, what);
    endtask

    task check_beat(logic [1:0] tuser, logic [15:0] tdata, logic tlast);
      lpd_res_t want;
      n_results++;
      if (expected_beats.size() == 0) begin
        report($sformatf("no beat expected, got kind %0d data %h last %b",
                         tuser, tdata, tlast));
        return;
      end
      want = expected_beats.pop_front();
      if (tuser !== want.out_kind)
        report($sformatf("out_kind %0d, want %0d", tuser, want.out_kind));
      if (tdata[7:0] !== want.out_byte)
        report($sformatf("out_byte %h, want %h", tdata[7:0], want.out_byte));
      if (tlast !== want.last)
        report($sformatf("last %b, want %b", tlast, want.last));
      if (tdata[9:8] !== want.err_code)
        report($sformatf("err_code %0d, want %0d", tdata[9:8], want.err_code));
      if (tdata[15:10] !== '0)
        report($sformatf("tdata pad bits %b, want 0", tdata[15:10]));
    endtask

    function int pending();
      return expected_beats.size();
    endfunction

    function bit at_boundary();
      return phase == RX_HEADER && hdr_cnt == 0;
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for length_prefixed_deframer: directed frames, then
// random frame traffic under several register settings, mostly with random idling.
// Depends on lpd_pkg (RTL) and lpd_tb_pkg (scoreboard).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpd_pkg::*;
  import lpd_tb_pkg::*;

  localparam int DRAIN_CYCLES = 8;     // margin after the last expected beat drains
  localparam int QUIET_LIMIT  = 2000;  // cycles with no beat moving before giving up
  localparam int MAX_BODY     = 24;    // cap on body bytes sent per frame

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] in_byte
  logic [1:0]  s_tuser   = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;          // [7:0] out_byte, [9:8] err_code
  logic [1:0]  m_tuser;          // [1:0] out_kind
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  frame_scoreboard sb = new;

  bit          idle_on = 1'b0;   // random gaps/stalls enabled
  int          n_sent  = 0;      // input beats accepted
  logic [31:0] cur_max = 32'd65536;
  int          quiet   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  length_prefixed_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Output monitor: every accepted beat goes to the scoreboard. Values read at
  // the edge are the ones the DUT saw, since all TB drives are nonblocking.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tuser, m_tdata, m_tlast);
  end

  // Sink pacing: random stall bursts while idling is on.
  initial begin : sink_pacing
    int stall;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Watchdog: a run where nothing moves for too long is a hang.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one beat, optionally after a gap burst, and hold it until taken.
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_input(kind, data);
    n_sent++;
  endtask

  task automatic send_header(input logic [63:0] len);
    for (int i = 7; i >= 0; i--) send_beat(KIND_BYTE, len[i*8 +: 8]);
  endtask

  task automatic maybe_tick(input int pct);
    if ($urandom_range(0, 99) < pct) send_beat(KIND_TICK, 8'($urandom));
  endtask

  // Stop driving, let every expected beat drain, then give in-flight beats
  // that produce nothing time to clear the pipeline.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back (spare index included), only when idle.
  task automatic apply_setting(input logic [31:0] max_b, input logic empty_ok,
                               input logic [31:0] tmo);
    logic [31:0] vals [4];
    settle();
    vals[REG_MAX_BYTES]   = max_b;
    vals[REG_ALLOW_EMPTY] = {31'b0, empty_ok};
    vals[REG_TIMEOUT]     = tmo;
    vals[REG_SPARE]       = $urandom;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_we  <= 1'b0;
    cur_max = max_b;
  endtask

  // Random traffic: mostly well-formed frames with ticks sprinkled in,
  // plus noise beats and headers torn off by a restart.
  task automatic run_frames(input int n_items, input int tick_pct);
    int          stop_at;
    int          sel;
    int          body_n;
    logic [63:0] len;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      // get back to a clean frame start after a halt or a partial frame
      if (!sb.at_boundary()) send_beat(KIND_RESTART, 8'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        repeat ($urandom_range(1, 4)) send_beat(2'($urandom), 8'($urandom));
      end else if (sel < 18) begin
        repeat ($urandom_range(1, 7)) send_beat(KIND_BYTE, 8'($urandom));
        send_beat(KIND_RESTART, 8'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 8)                        len = '0;
        else if (sel < 16)                  len = {32'h0, cur_max} + 64'($urandom_range(1, 3));
        else if (sel < 22)                  len = {$urandom, $urandom};
        else if (sel < 30 && cur_max <= MAX_BODY) len = {32'h0, cur_max};
        else                                len = 64'($urandom_range(1, 12));
        for (int i = 7; i >= 0; i--) begin
          maybe_tick(tick_pct);
          send_beat(KIND_BYTE, len[i*8 +: 8]);
        end
        if (len == 0 || len > {32'h0, cur_max}) body_n = 0;
        else if (len > MAX_BODY)              body_n = MAX_BODY;
        else                                  body_n = int'(len);
        for (int i = 0; i < body_n; i++) begin
          maybe_tick(tick_pct);
          send_beat(KIND_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, on reset register values (max 65536, empty rejected, no timeout).
    send_header(64'd1);                  // one-byte frame
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_TICK, 8'hFF);         // tick without timeout: silent
    send_beat(KIND_UNUSED, 8'hFF);       // unused kind: ignored
    send_header(64'd0);                  // empty frame rejected, block halts
    send_beat(KIND_BYTE, 8'hA5);         // dropped while halted
    send_beat(KIND_TICK, 8'h00);         // dropped while halted
    send_beat(KIND_RESTART, 8'hFF);
    send_beat(KIND_BYTE, 8'hFF);         // partial header ...
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_RESTART, 8'h00);      // ... thrown away by a restart

    // Random phases across register extremes.
    idle_on = 1'b1;
    apply_setting(32'd32, 1'b1, 32'd0);
    run_frames(300, 10);
    apply_setting(32'd0, 1'b1, 32'd50);  // every nonzero length too large
    run_frames(150, 10);
    apply_setting(32'hFFFF_FFFF, 1'b0, 32'd1);  // first tick always times out
    run_frames(250, 8);
    apply_setting(32'($urandom_range(1, 20)), 1'($urandom), 32'($urandom_range(3, 12)));
    run_frames(300, 25);
    idle_on = 1'b0;                      // closing stretch at full rate
    apply_setting(32'd16, 1'b1, 32'hFFFF_FFFF);
    run_frames(250, 10);

    settle();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
